[hdl/irp_pkg.sv]
package irp_pkg;

	localparam int SIGMOID_SEGMENTS = 64;
	localparam int SEG_W            = $clog2(SIGMOID_SEGMENTS + 1);
	localparam int CLAMP_SHIFT      = 39;
	localparam int CLAMP_W          = CLAMP_SHIFT + 1;
	localparam int FRAC_W           = CLAMP_SHIFT;
	localparam int ZMAG_W           = 48;
	localparam int SERIES_TERMS     = 80;
	localparam longint unsigned KNOT_SPAN_Q16 = 64'd524288;
	localparam logic [15:0] SCALE_RESET = 16'd6971;

	// accept edge to the edge that takes the result
	localparam int IRP_LATENCY = 8;

	typedef logic [SIGMOID_SEGMENTS:0][15:0] knot_rom_t;

	typedef struct packed {
		logic              valid;
		logic              neg;
		logic [ZMAG_W-1:0] zmag;
		logic [15:0]       guessing;
		logic              last;
	} irp_arg_t;

	typedef struct packed {
		logic        valid;
		logic [16:0] sig;
		logic [15:0] guessing;
		logic        last;
	} irp_sig_t;

	// shift and subtract quotient, used only while building the knot ROM
	function automatic longint unsigned div_u64(input longint unsigned num,
		input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// logistic knot e^x / (e^x + 1) in Q0.16, e^x from a truncated series in Q32
	function automatic logic [15:0] knot_value(input longint unsigned xq16);
		longint unsigned term;
		longint unsigned sum;
		longint unsigned den;
		longint unsigned num;
		logic            stop;
		term = 64'd1 << 32;
		sum  = term;
		stop = 1'b0;
		for (int n = 1; n <= SERIES_TERMS; n++) begin
			if (!stop) begin
				term = div_u64((term * xq16) >> 16, longint'(unsigned'(n)));
				if (term == 64'd0) begin
					stop = 1'b1;
				end else begin
					sum = sum + term;
				end
			end
		end
		den = sum + (64'd1 << 32);
		num = (sum << 16) + (den >> 1);
		return 16'(div_u64(num, den));
	endfunction

	function automatic knot_rom_t build_knots();
		knot_rom_t       rom;
		longint unsigned x;
		for (int k = 0; k <= SIGMOID_SEGMENTS; k++) begin
			x = (longint'(unsigned'(k)) * KNOT_SPAN_Q16) / SIGMOID_SEGMENTS;
			rom[k] = knot_value(x);
		end
		return rom;
	endfunction

	localparam knot_rom_t KNOT_ROM = build_knots();

endpackage

[hdl/irp_arg.sv]
module irp_arg import irp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [15:0] theta,
	input  logic [15:0]        discrimination,
	input  logic signed [15:0] difficulty,
	input  logic [15:0]        guessing,
	input  logic               last_threshold,
	input  logic [15:0]        scale,
	output irp_arg_t           arg
);

	logic signed [16:0] diff;
	logic               neg;
	logic [15:0]        mag;

	logic               valid_s1, neg_s1, last_s1;
	logic [15:0]        mag_s1, c_s1;
	logic [31:0]        da_s1;

	logic               valid_s2, neg_s2, last_s2;
	logic [15:0]        c_s2;
	logic [ZMAG_W-1:0]  zmag_s2;

	// |theta - b| fits 16 bits: the difference lies in [-65535, 65535]
	assign diff = {theta[15], theta} - {difficulty[15], difficulty};
	assign neg  = diff[16];
	assign mag  = neg ? 16'(-diff) : 16'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= neg;
		mag_s1  <= mag;
		da_s1   <= scale * discrimination;
		c_s1    <= guessing;
		last_s1 <= last_threshold;

		neg_s2  <= neg_s1;
		zmag_s2 <= ZMAG_W'(da_s1) * ZMAG_W'(mag_s1);
		c_s2    <= c_s1;
		last_s2 <= last_s1;
	end

	assign arg.valid    = valid_s2;
	assign arg.neg      = neg_s2;
	assign arg.zmag     = zmag_s2;
	assign arg.guessing = c_s2;
	assign arg.last     = last_s2;

endmodule

[hdl/irp_sigmoid.sv]
module irp_sigmoid import irp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  irp_arg_t arg,
	output irp_sig_t sig
);

	localparam int P_W = CLAMP_SHIFT + SEG_W;
	localparam logic [CLAMP_W-1:0] LIM = CLAMP_W'(1) << CLAMP_SHIFT;

	logic [CLAMP_W-1:0]       zc;
	logic [P_W-1:0]           p;
	logic [SEG_W-1:0]         kn;
	logic                     at_end;
	logic signed [16:0]       delta;
	logic signed [16:0]       step;
	logic [16:0]              y;

	logic                     valid_s3, neg_s3, last_s3;
	logic [15:0]              c_s3;
	logic [SEG_W-1:0]         k_s3;
	logic [FRAC_W-1:0]        f_s3;

	logic                     valid_s4, neg_s4, last_s4;
	logic [15:0]              c_s4, base_s4;
	logic signed [16:0]       delta_s4;
	logic [FRAC_W-1:0]        f_s4;

	logic                     valid_s5, neg_s5, last_s5;
	logic [15:0]              c_s5, base_s5;
	logic signed [FRAC_W+17:0] prod_s5;

	logic                     valid_s6, last_s6;
	logic [15:0]              c_s6;
	logic [16:0]              s_s6;

	// clamp |z| to 8, then split |z| * segments into segment and fraction
	assign zc = (arg.zmag > ZMAG_W'(LIM)) ? LIM : arg.zmag[CLAMP_W-1:0];
	assign p  = P_W'(zc) * P_W'(SIGMOID_SEGMENTS);

	// end segment: hold the last knot, no slope
	assign at_end = (k_s3 >= SEG_W'(SIGMOID_SEGMENTS));
	assign kn     = at_end ? SEG_W'(SIGMOID_SEGMENTS) : k_s3 + SEG_W'(1);
	assign delta  = at_end ? 17'sd0 :
		$signed({1'b0, KNOT_ROM[kn]}) - $signed({1'b0, KNOT_ROM[k_s3]});

	// floor of the slope term, arithmetic shift keeps floor for a negative slope
	assign step = 17'(prod_s5 >>> FRAC_W);
	assign y    = 17'({1'b0, base_s5}) + 17'(step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s3 <= arg.valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		neg_s3   <= arg.neg;
		c_s3     <= arg.guessing;
		last_s3  <= arg.last;
		k_s3     <= p[CLAMP_SHIFT +: SEG_W];
		f_s3     <= p[FRAC_W-1:0];

		neg_s4   <= neg_s3;
		c_s4     <= c_s3;
		last_s4  <= last_s3;
		base_s4  <= at_end ? KNOT_ROM[SIGMOID_SEGMENTS] : KNOT_ROM[k_s3];
		delta_s4 <= delta;
		f_s4     <= f_s3;

		neg_s5   <= neg_s4;
		c_s5     <= c_s4;
		last_s5  <= last_s4;
		base_s5  <= base_s4;
		prod_s5  <= delta_s4 * $signed({1'b0, f_s4});

		c_s6     <= c_s5;
		last_s6  <= last_s5;
		s_s6     <= neg_s5 ? 17'h10000 - y : y;
	end

	assign sig.valid    = valid_s6;
	assign sig.sig      = s_s6;
	assign sig.guessing = c_s6;
	assign sig.last     = last_s6;

endmodule

[hdl/irp_mix.sv]
module irp_mix import irp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  irp_sig_t    sig,
	output logic        done,
	output logic [15:0] probability,
	output logic        last_out
);

	logic        valid_s7, last_s7;
	logic [15:0] c_s7;
	logic [33:0] prod_s7;
	logic [34:0] acc;

	logic        done_q, last_q;
	logic [15:0] prob_q;

	// c + (1 - c) * s, rounded half up
	assign acc = 35'(prod_s7) + {3'b0, c_s7, 16'h0} + 35'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s7 <= sig.valid;
			done_q   <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		c_s7    <= sig.guessing;
		last_s7 <= sig.last;
		prod_s7 <= (17'h10000 - 17'(sig.guessing)) * sig.sig;

		last_q  <= last_s7;
		prob_q  <= (acc[34:32] != 3'b0) ? 16'hFFFF : acc[31:16];
	end

	assign done        = done_q;
	assign probability = prob_q;
	assign last_out    = last_q;

endmodule

[hdl/item_response_probability_core.sv]
// Three-parameter logistic response probability, c + (1 - c) * sigmoid(D*a*(theta - b)).
//
// Input: one transfer per rising edge with start high and busy low. busy is
// never raised, so a new item (theta, discrimination, difficulty, guessing,
// last_threshold) may enter on every cycle. A polytomous item is sent as one
// transfer per threshold with last_threshold set on the final one.
// Output: each transfer yields one result. done is high for exactly one cycle
// with probability (Q0.16, saturated) and last_out; the receiver takes it at
// the edge that ends that cycle and cannot hold it off, so nothing stalls.
// Throughput: one item per cycle, through the eight pipeline registers
// (difference and D*a, z product, segment split, knot lookup, slope product,
// sign fold, guessing blend, output register).
// Config: scale_wdata is written to D (unsigned Q4.12) at an edge with
// scale_we high; write it only while no item is in flight.
// Reset: arst_n clears all valid bits at once and loads D = 6971 (about 1.702).
// The knot table is a constant ROM, so there is no start-up sweep.
module item_response_probability_core import irp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] theta,
	input  logic [15:0]        discrimination,
	input  logic signed [15:0] difficulty,
	input  logic [15:0]        guessing,
	input  logic               last_threshold,
	input  logic               scale_we,
	input  logic [15:0]        scale_wdata,
	output logic               done,
	output logic [15:0]        probability,
	output logic               last_out
);

	logic [15:0] scale_q;
	irp_arg_t    arg;
	irp_sig_t    sig;

	// fully pipelined, never refuses a transfer
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (scale_we) begin
			scale_q <= scale_wdata;
		end
	end

	// stages 1-2: theta - b, D*a, then the exact argument magnitude
	irp_arg u_arg (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (start & ~busy),
		.theta          (theta),
		.discrimination (discrimination),
		.difficulty     (difficulty),
		.guessing       (guessing),
		.last_threshold (last_threshold),
		.scale          (scale_q),
		.arg            (arg)
	);

	// stages 3-6: clamp, piecewise-linear sigmoid, sign fold
	irp_sigmoid u_sigmoid (
		.clk    (clk),
		.arst_n (arst_n),
		.arg    (arg),
		.sig    (sig)
	);

	// stages 7-8: guessing floor blend, rounding, saturation
	irp_mix u_mix (
		.clk         (clk),
		.arst_n      (arst_n),
		.sig         (sig),
		.done        (done),
		.probability (probability),
		.last_out    (last_out)
	);

endmodule

[hdl/irp_checker.sv]
module irp_checker import irp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [15:0] discrimination,
	input logic [15:0] guessing,
	input logic        last_threshold,
	input logic        done,
	input logic [15:0] probability,
	input logic        last_out
);

	// every transfer in gives a result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##IRP_LATENCY done)
		else $error("missing result after accepted transfer");

	// no result without a transfer in
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, IRP_LATENCY))
		else $error("result without matching transfer");

	a_last_tag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> last_out == $past(last_threshold, IRP_LATENCY))
		else $error("last_out does not match its item");

	// the guessing floor bounds the result from below
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> probability >= $past(guessing, IRP_LATENCY))
		else $error("probability below guessing floor");

	// flat item with no floor sits at one half
	a_flat_half: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && discrimination == 16'h0 && guessing == 16'h0
		|-> ##IRP_LATENCY probability == 16'h8000)
		else $error("zero discrimination does not give one half");

endmodule

bind item_response_probability_core irp_checker u_irp_checker (.*);
